/* sv/spd_pkg.sv */
`default_nettype none

package spd_pkg;

    // Frame phases
    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_HDR_HI  = 3'd1;
    localparam logic [2:0] PH_SUM     = 3'd2;
    localparam logic [2:0] PH_LEN_LO  = 3'd3;
    localparam logic [2:0] PH_LEN_HI  = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;

    // Result event codes
    localparam logic [2:0] EV_BYTE    = 3'd0;
    localparam logic [2:0] EV_LAST    = 3'd1;
    localparam logic [2:0] EV_EMPTY   = 3'd2;
    localparam logic [2:0] EV_BADLEN  = 3'd3;
    localparam logic [2:0] EV_TIMEOUT = 3'd4;

    // Input word kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_HEADER  = 2'd0;
    localparam logic [1:0] CFG_MAX_LEN = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT = 2'd2;

    localparam logic [15:0] HEADER_RST  = 16'h55AA;
    localparam logic [15:0] MAX_LEN_RST = 16'd250;
    localparam logic [15:0] TIMEOUT_RST = 16'd20;

    typedef struct packed {
        logic [15:0] header_word;
        logic [15:0] max_payload_len;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        logic [2:0]  event_res;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic        checksum_ok;
    } result_t;

endpackage

`default_nettype wire

/* sv/spd_fsm.sv */
`default_nettype none

module spd_fsm (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           step,
    input  wire logic           req_type,
    input  wire logic [7:0]     rx_byte,
    input  wire spd_pkg::cfg_t  cfg,
    output spd_pkg::result_t    res
);
    import spd_pkg::*;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  len_lo_reg, len_lo_next;
    logic [15:0] remain_reg, remain_next;
    logic [15:0] pos_reg, pos_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  sum_reg, sum_next;
    logic [15:0] idle_reg, idle_next;

    logic [15:0] len;
    logic [15:0] idle_inc;
    logic [15:0] remain_dec;
    logic [7:0]  xor_upd;

    assign len        = {rx_byte, len_lo_reg};
    assign idle_inc   = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
    assign remain_dec = remain_reg - 16'd1;
    assign xor_upd    = xor_reg ^ rx_byte;

    // Per-word state update and result
    always_comb begin
        phase_next  = phase_reg;
        len_lo_next = len_lo_reg;
        remain_next = remain_reg;
        pos_next    = pos_reg;
        xor_next    = xor_reg;
        sum_next    = sum_reg;
        idle_next   = idle_reg;
        res         = '0;

        if (req_type == REQ_TICK) begin
            // ticks only count inside a frame; unused codes behave as hunting
            if (phase_reg != PH_HUNT && phase_reg <= PH_PAYLOAD) begin
                if (idle_inc >= cfg.timeout_ticks) begin
                    phase_next    = PH_HUNT;
                    idle_next     = '0;
                    res.valid     = 1'b1;
                    res.event_res = EV_TIMEOUT;
                end else begin
                    idle_next = idle_inc;
                end
            end else begin
                phase_next = PH_HUNT;
            end
        end else begin
            idle_next = '0;
            unique case (phase_reg)
                PH_HDR_HI: begin
                    phase_next = (rx_byte == cfg.header_word[15:8]) ? PH_SUM : PH_HUNT;
                end
                PH_SUM: begin
                    sum_next   = rx_byte;
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    len_lo_next = rx_byte;
                    phase_next  = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    if (len > cfg.max_payload_len) begin
                        phase_next    = PH_HUNT;
                        res.valid     = 1'b1;
                        res.event_res = EV_BADLEN;
                    end else if (len == 16'd0) begin
                        phase_next      = PH_HUNT;
                        res.valid       = 1'b1;
                        res.event_res   = EV_EMPTY;
                        res.checksum_ok = (sum_reg == 8'd0);
                    end else begin
                        remain_next = len;
                        pos_next    = '0;
                        xor_next    = '0;
                        phase_next  = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    xor_next         = xor_upd;
                    remain_next      = remain_dec;
                    pos_next         = pos_reg + 16'd1;
                    res.valid        = 1'b1;
                    res.payload_byte = rx_byte;
                    res.byte_index   = pos_reg;
                    if (remain_dec == 16'd0) begin
                        phase_next      = PH_HUNT;
                        res.event_res   = EV_LAST;
                        res.checksum_ok = (xor_upd == sum_reg);
                    end else begin
                        res.event_res = EV_BYTE;
                    end
                end
                default: begin
                    // hunting, or an unused code
                    phase_next = (rx_byte == cfg.header_word[7:0]) ? PH_HDR_HI : PH_HUNT;
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HUNT;
            len_lo_reg <= '0;
            remain_reg <= '0;
            pos_reg    <= '0;
            xor_reg    <= '0;
            sum_reg    <= '0;
            idle_reg   <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            len_lo_reg <= len_lo_next;
            remain_reg <= remain_next;
            pos_reg    <= pos_next;
            xor_reg    <= xor_next;
            sum_reg    <= sum_next;
            idle_reg   <= idle_next;
        end
    end

endmodule

`default_nettype wire

/* sv/serial_packet_deframer_core.sv */
`default_nettype none

// Serial packet deframer. Each input word is either a received byte or one
// timer tick (s_tuser). Frames are: header low byte, header high byte,
// checksum byte, payload length low/high, then payload. Every payload byte
// is forwarded as it arrives with its index; the final one also reports
// whether the XOR of the payload matched the checksum byte. Empty frames,
// oversize lengths and inter-byte timeouts give one event each; header
// mismatches and ticks while hunting give nothing. The block takes one word
// per cycle: a taken word sits in the input register, and the frame state
// update writes the result register when that is free or drained. Input
// throughput drops only while a waiting result is held by a low m_tready.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata; the user must
// write it only while the block is idle, which the block does not enforce.
module serial_packet_deframer_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input words
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [0:0]  s_tuser,   // [0] req_type
    // result words
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] payload_byte, [23:8] byte_index,
                                        // [24] checksum_ok, [31:25] zero
    output logic [2:0]       m_tuser,   // [2:0] event_res
    // configuration writes
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata
);
    import spd_pkg::*;

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    logic        in_type_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg;
    logic [2:0]  out_user_reg;
    logic        advance;
    result_t     res;

    // The input register moves on when the result register is free or drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_word     <= HEADER_RST;
            cfg_reg.max_payload_len <= MAX_LEN_RST;
            cfg_reg.timeout_ticks   <= TIMEOUT_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_HEADER:  cfg_reg.header_word     <= cfg_wdata;
                CFG_MAX_LEN: cfg_reg.max_payload_len <= cfg_wdata;
                CFG_TIMEOUT: cfg_reg.timeout_ticks   <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_type_reg <= s_tuser[0];
            in_byte_reg <= s_tdata;
        end
    end

    spd_fsm u_fsm (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (advance),
        .req_type (in_type_reg),
        .rx_byte  (in_byte_reg),
        .cfg      (cfg_reg),
        .res      (res)
    );

    // Result register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = res.valid;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res.valid) begin
            out_data_reg <= {7'd0, res.checksum_ok, res.byte_index, res.payload_byte};
            out_user_reg <= res.event_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // Checks
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    a_event_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= EV_TIMEOUT))
        else $error("event code out of range");

    a_no_payload_on_events: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != EV_BYTE && m_tuser != EV_LAST) |-> (m_tdata[23:0] == 24'd0))
        else $error("payload fields set on a non-byte event");

    a_clean_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

/* tb/serial_packet_deframer_core_tb.sv */
`timescale 1ns / 1ps

module serial_packet_deframer_core_tb;
    import spd_pkg::*;

    localparam int unsigned WATCHDOG_CYCLES = 400000;
    localparam int unsigned SETTLE_CYCLES   = 10;
    localparam int unsigned PHASE_WORDS     = 390;
    localparam int unsigned MAX_REPORTS     = 10;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
    } rx_word_t;

    typedef struct packed {
        logic [2:0]  ev;
        logic [7:0]  payload;
        logic [15:0] index;
        logic        ok;
    } frame_event_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic [0:0]  s_tuser   = REQ_BYTE;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_addr  = CFG_HEADER;
    logic [15:0] cfg_wdata = 16'h0000;

    serial_packet_deframer_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Shadow copy of the registers
    logic [15:0] hdr     = HEADER_RST;
    logic [15:0] max_len = MAX_LEN_RST;
    logic [15:0] tmo     = TIMEOUT_RST;

    // Shadow frame state
    logic [2:0]  ph        = PH_HUNT;
    logic [7:0]  len_lo    = 8'h00;
    logic [15:0] remaining = 16'h0000;
    logic [15:0] position  = 16'h0000;
    logic [7:0]  run_xor   = 8'h00;
    logic [7:0]  exp_sum   = 8'h00;
    logic [15:0] idle      = 16'h0000;

    rx_word_t     pending_words[$];
    frame_event_t expected_events[$];
    rx_word_t     next_word;

    int unsigned words_pushed = 0;
    int unsigned words_taken  = 0;
    int unsigned mismatches   = 0;
    int unsigned cycles       = 0;
    int unsigned idle_pct     = 28;
    logic        word_taken   = 1'b0;

    // Frame tracker: updates shadow state and queues the event the word causes
    function automatic void predict_deframer(input logic kind, input logic [7:0] b);
        logic [15:0]  len;
        frame_event_t e;
        e = '0;
        if (ph > PH_PAYLOAD) ph = PH_HUNT;
        if (kind == REQ_TICK) begin
            if (ph == PH_HUNT) return;
            if (idle != 16'hFFFF) idle = idle + 16'd1;
            if (idle >= tmo) begin
                ph = PH_HUNT;
                idle = 16'h0000;
                e.ev = EV_TIMEOUT;
                expected_events.push_back(e);
            end
            return;
        end
        idle = 16'h0000;
        case (ph)
            PH_HUNT: begin
                if (b == hdr[7:0]) ph = PH_HDR_HI;
            end
            PH_HDR_HI: begin
                ph = (b == hdr[15:8]) ? PH_SUM : PH_HUNT;
            end
            PH_SUM: begin
                exp_sum = b;
                ph = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                len_lo = b;
                ph = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                len = {b, len_lo};
                if (len > max_len) begin
                    ph = PH_HUNT;
                    e.ev = EV_BADLEN;
                    expected_events.push_back(e);
                end else if (len == 16'h0000) begin
                    ph = PH_HUNT;
                    e.ev = EV_EMPTY;
                    e.ok = (exp_sum == 8'h00);
                    expected_events.push_back(e);
                end else begin
                    remaining = len;
                    position = 16'h0000;
                    run_xor = 8'h00;
                    ph = PH_PAYLOAD;
                end
            end
            default: begin
                e.payload = b;
                e.index = position;
                run_xor = run_xor ^ b;
                remaining = remaining - 16'd1;
                position = position + 16'd1;
                if (remaining != 16'h0000) begin
                    e.ev = EV_BYTE;
                end else begin
                    ph = PH_HUNT;
                    e.ev = EV_LAST;
                    e.ok = (run_xor == exp_sum);
                end
                expected_events.push_back(e);
            end
        endcase
    endfunction

    function automatic void flag_mismatch(input string what, input frame_event_t want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] %s: expected ev=%0d byte=%02h idx=%0d ok=%0b, got ev=%0d byte=%02h idx=%0d ok=%0b",
                     $realtime, what, want.ev, want.payload, want.index, want.ok,
                     m_tuser, m_tdata[7:0], m_tdata[23:8], m_tdata[24]);
    endfunction

    // Input side: note accepted words and run them through the tracker
    // Output side: compare each result word with the oldest expectation
    always @(posedge aclk) begin
        frame_event_t want;
        cycles++;
        word_taken = s_tvalid && s_tready;
        if (word_taken) begin
            predict_deframer(s_tuser[0], s_tdata);
            words_taken++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_events.size() == 0) begin
                flag_mismatch("result with nothing pending", '0);
            end else begin
                want = expected_events.pop_front();
                if (m_tuser !== want.ev || m_tdata[7:0] !== want.payload ||
                    m_tdata[23:8] !== want.index || m_tdata[24] !== want.ok)
                    flag_mismatch("result mismatch", want);
            end
        end
    end

    // Driver and sink stalls, both change on the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || word_taken) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
                next_word = pending_words.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= next_word.kind;
                s_tdata <= next_word.data;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(99) >= idle_pct);
    end

    // Watchdog
    always @(posedge aclk) begin
        if (cycles > WATCHDOG_CYCLES) begin
            $display("serial_packet_deframer_core verification failed");
            $finish;
        end
    end

    task automatic push_word(input logic kind, input logic [7:0] b);
        pending_words.push_back('{kind: kind, data: b});
        words_pushed++;
    endtask

    // Queue a frame with the current header; only the first 'sent' bytes go out.
    // Short tick gaps (below the timeout) are sprinkled between bytes.
    task automatic push_frame(input int unsigned len, input bit good_sum,
                              input int unsigned sent);
        logic [7:0]  body[$];
        logic [7:0]  head[5];
        logic [7:0]  xsum;
        logic [15:0] len16;
        int unsigned gap_max;
        xsum = 8'h00;
        len16 = len[15:0];
        for (int unsigned i = 0; i + 5 < sent; i++) begin
            body.push_back(8'($urandom_range(255)));
            xsum ^= body[i];
        end
        if (!good_sum) xsum ^= 8'($urandom_range(255, 1));
        head = '{hdr[7:0], hdr[15:8], xsum, len16[7:0], len16[15:8]};
        gap_max = (tmo > 16'd7) ? 6 : int'(tmo) - 1;
        for (int unsigned i = 0; i < sent; i++) begin
            push_word(REQ_BYTE, (i < 5) ? head[i] : body[i - 5]);
            if (gap_max != 0 && $urandom_range(7) == 0)
                repeat ($urandom_range(gap_max, 1))
                    push_word(REQ_TICK, 8'($urandom_range(255)));
        end
    endtask

    // Mostly well-formed frames, plus oversize lengths, abandoned frames and noise
    task automatic random_traffic(input int unsigned budget);
        int unsigned start;
        int unsigned sel;
        int unsigned cap;
        int unsigned len;
        start = words_pushed;
        while (words_pushed - start < budget) begin
            sel = $urandom_range(99);
            cap = (max_len < 16'd12) ? max_len : 12;
            if (sel < 70 || (sel < 80 && max_len == 16'hFFFF) ||
                (sel < 88 && tmo > 16'd40)) begin
                if ($urandom_range(19) == 0) cap = (max_len < 16'd300) ? max_len : 300;
                len = $urandom_range(cap);
                if ($urandom_range(24) == 0 && max_len <= 16'd300) len = max_len;
                push_frame(len, $urandom_range(3) != 0, len + 5);
            end else if (sel < 80) begin
                len = ($urandom_range(2) == 0) ? max_len + 1 :
                      $urandom_range(65535, max_len + 1);
                push_frame(len, 1'b1, 5);
            end else if (sel < 88) begin
                len = (max_len == 16'd0) ? 0 : $urandom_range(cap, 1);
                push_frame(len, 1'b1, $urandom_range(4 + len, 1));
                repeat (tmo) push_word(REQ_TICK, 8'($urandom_range(255)));
            end else begin
                repeat ($urandom_range(6, 1))
                    push_word(1'($urandom_range(1)), 8'($urandom_range(255)));
            end
        end
    endtask

    // Hold off until every word is taken and every result has come back
    task automatic wait_drained();
        while (words_taken != words_pushed || expected_events.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_HEADER:  hdr = val;
            CFG_MAX_LEN: max_len = val;
            CFG_TIMEOUT: tmo = val;
            default: ;
        endcase
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: tick while hunting, bad second header byte (not rechecked),
        // empty frames with zero and nonzero sum, oversize length, 1-byte frame
        push_word(REQ_TICK, 8'hFF);
        push_word(REQ_BYTE, 8'hAA);
        push_word(REQ_BYTE, 8'hAA);
        push_word(REQ_BYTE, 8'h55);
        push_frame(0, 1'b1, 5);
        push_frame(0, 1'b0, 5);
        push_frame(16'hFFFF, 1'b1, 5);
        push_frame(1, 1'b0, 6);
        push_word(REQ_BYTE, 8'h00);
        random_traffic(PHASE_WORDS);
        wait_drained();

        // Zero header, empty frames only, one-tick timeout
        write_reg(CFG_HEADER, 16'h0000);
        write_reg(CFG_MAX_LEN, 16'h0000);
        write_reg(CFG_TIMEOUT, 16'd1);
        push_frame(0, 1'b0, 2);
        push_word(REQ_TICK, 8'h00);
        push_frame(1, 1'b1, 5);
        random_traffic(PHASE_WORDS);
        wait_drained();

        // All-ones header, no length limit, longest timeout, no stalls
        write_reg(CFG_HEADER, 16'hFFFF);
        write_reg(CFG_MAX_LEN, 16'hFFFF);
        write_reg(CFG_TIMEOUT, 16'hFFFF);
        idle_pct = 0;
        push_frame(300, 1'b1, 305);
        random_traffic(PHASE_WORDS);
        wait_drained();
        idle_pct = 28;

        write_reg(CFG_HEADER, 16'h1234);
        write_reg(CFG_MAX_LEN, 16'd16);
        write_reg(CFG_TIMEOUT, 16'd5);
        random_traffic(PHASE_WORDS);
        wait_drained();

        write_reg(CFG_HEADER, 16'($urandom_range(65535)));
        write_reg(CFG_MAX_LEN, 16'($urandom_range(40, 1)));
        write_reg(CFG_TIMEOUT, 16'($urandom_range(12, 2)));
        random_traffic(PHASE_WORDS);
        wait_drained();

        if (mismatches == 0 && expected_events.size() == 0) begin
            $display("serial_packet_deframer_core verification clean");
        end else begin
            $display("serial_packet_deframer_core verification failed");
        end
        $finish;
    end

endmodule
